// File: rtl/button_debounce_event_engine_defines.svh
// Assertion helpers used by the checker of the button event engine.
`ifndef BUTTON_DEBOUNCE_EVENT_ENGINE_DEFINES_SVH
`define BUTTON_DEBOUNCE_EVENT_ENGINE_DEFINES_SVH

// Same-cycle implication, sampled on clock, quiet during reset
`define BDE_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clock, quiet during reset
`define BDE_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/bde_pkg.sv
`timescale 1ns / 1ps
package bde_pkg;

   // Button set
   localparam int BUTTONS         = 8;
   localparam int BTN_SLOTS       = 8;
   localparam int BTN_IDX_W       = $clog2(BTN_SLOTS);
   localparam int ZOOM_IN_BUTTON  = 0;
   localparam int ZOOM_OUT_BUTTON = 1;
   localparam int CENTER_BUTTON   = 4;

   // Fixed values
   localparam logic [4:0] ZOOM_START   = 5'd14;
   localparam logic [1:0] TALLY_MAX    = 2'd3;
   localparam logic [1:0] DOUBLE_COUNT = 2'd2;

   // Item kinds on the request side
   localparam logic MODE_SCAN = 1'b0;
   localparam logic MODE_POLL = 1'b1;

   // Configuration register map
   localparam int         CSR_AW        = 5;
   localparam logic [2:0] REG_DEBOUNCE  = 3'd0;
   localparam logic [2:0] REG_HOLD      = 3'd1;
   localparam logic [2:0] REG_DCLICK    = 3'd2;
   localparam logic [2:0] REG_SCAN_IV   = 3'd3;
   localparam logic [2:0] REG_ZOOM_LO   = 3'd4;
   localparam logic [2:0] REG_ZOOM_HI   = 3'd5;

   // Result item layout in rsp_tdata
   localparam int RSP_KIND_LSB   = 0;
   localparam int RSP_BTN_LSB    = 2;
   localparam int RSP_DOWN_LSB   = 5;
   localparam int RSP_ZOOM_LSB   = 13;
   localparam int RSP_SELECT_BIT = 18;
   localparam int RSP_TAKEN_BIT  = 19;
   localparam int RSP_W          = 24;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_PRESS  = 2'd1,
      EV_HOLD   = 2'd2,
      EV_DOUBLE = 2'd3
   } bde_event_type;

   typedef struct packed {
      logic [15:0] debounce;
      logic [15:0] hold;
      logic [15:0] dclick;
      logic [7:0]  scan_iv;
      logic [4:0]  zoom_lo;
      logic [4:0]  zoom_hi;
   } bde_cfg_type;

   // Per-button control from the top level
   typedef struct packed {
      logic scan;
      logic clr_pend;
      logic clr_tally;
   } bde_cell_ctl_type;

   // Per-button status toward zoom logic and poll arbiter
   typedef struct packed {
      logic down;
      logic down_nx;
      logic pend_scan;
      logic pending;
      logic hold_hit;
      logic dbl_hit;
   } bde_cell_stat_type;

endpackage

// File: rtl/bde_csr.sv
`timescale 1ns / 1ps
module bde_csr import bde_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output bde_cfg_type       cfg
);

   bde_cfg_type cfg_ff, cfg_in;
   logic        wr_en;
   logic [2:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_idx    = csr_paddr[CSR_AW-1:2];
   assign cfg        = cfg_ff;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_DEBOUNCE: cfg_in.debounce = csr_pwdata[15:0];
            REG_HOLD:     cfg_in.hold     = csr_pwdata[15:0];
            REG_DCLICK:   cfg_in.dclick   = csr_pwdata[15:0];
            REG_SCAN_IV:  cfg_in.scan_iv  = csr_pwdata[7:0];
            REG_ZOOM_LO:  cfg_in.zoom_lo  = csr_pwdata[4:0];
            REG_ZOOM_HI:  cfg_in.zoom_hi  = csr_pwdata[4:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         REG_DEBOUNCE: csr_prdata = {16'd0, cfg_ff.debounce};
         REG_HOLD:     csr_prdata = {16'd0, cfg_ff.hold};
         REG_DCLICK:   csr_prdata = {16'd0, cfg_ff.dclick};
         REG_SCAN_IV:  csr_prdata = {24'd0, cfg_ff.scan_iv};
         REG_ZOOM_LO:  csr_prdata = {27'd0, cfg_ff.zoom_lo};
         REG_ZOOM_HI:  csr_prdata = {27'd0, cfg_ff.zoom_hi};
         default:      csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce <= 16'd50;
         cfg_ff.hold     <= 16'd1000;
         cfg_ff.dclick   <= 16'd300;
         cfg_ff.scan_iv  <= 8'd5;
         cfg_ff.zoom_lo  <= 5'd10;
         cfg_ff.zoom_hi  <= 5'd18;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/bde_button_cell.sv
`timescale 1ns / 1ps
module bde_button_cell import bde_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  bde_cell_ctl_type  ctl,
   input  logic              pressed,
   input  logic [31:0]       now_ms,
   input  bde_cfg_type       cfg,
   output bde_cell_stat_type stat
);

   logic        down_ff, down_in;
   logic        pend_ff, pend_in;
   logic [31:0] press_t_ff, press_t_in;
   logic [31:0] rel_t_ff, rel_t_in;
   logic [1:0]  tally_ff, tally_in;

   logic [31:0] since_press, since_rel;
   logic        edge_ok, take_press, take_rel, dc_expired;
   logic        pend_scan;
   logic [1:0]  tally_scan;

   assign since_press = now_ms - press_t_ff;
   assign since_rel   = now_ms - rel_t_ff;

   // Accept a level change once either debounce window has passed
   assign edge_ok    = (since_rel > {16'd0, cfg.debounce}) |
                       (since_press > {16'd0, cfg.debounce});
   assign take_press = (pressed != down_ff) & edge_ok & pressed;
   assign take_rel   = (pressed != down_ff) & edge_ok & ~pressed;
   assign dc_expired = since_press > {16'd0, cfg.dclick};
   assign pend_scan  = pend_ff | take_press;

   // Count presses, drop the count once the double-click window runs out
   always_comb begin
      if (take_press) begin
         tally_scan = (tally_ff < TALLY_MAX) ? tally_ff + 2'd1 : tally_ff;
      end else if (dc_expired) begin
         tally_scan = 2'd0;
      end else begin
         tally_scan = tally_ff;
      end
   end

   // Next state
   always_comb begin
      down_in    = down_ff;
      press_t_in = press_t_ff;
      rel_t_in   = rel_t_ff;
      tally_in   = tally_ff;
      pend_in    = pend_ff;
      if (ctl.scan) begin
         down_in  = take_press | (down_ff & ~take_rel);
         tally_in = tally_scan;
         pend_in  = pend_scan;
         if (take_press) begin
            press_t_in = now_ms;
         end
         if (take_rel) begin
            rel_t_in = now_ms;
         end
      end
      if (ctl.clr_pend) begin
         pend_in = 1'b0;
      end
      if (ctl.clr_tally) begin
         tally_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff    <= 1'b0;
         pend_ff    <= 1'b0;
         press_t_ff <= 32'd0;
         rel_t_ff   <= 32'd0;
         tally_ff   <= 2'd0;
      end else begin
         down_ff    <= down_in;
         pend_ff    <= pend_in;
         press_t_ff <= press_t_in;
         rel_t_ff   <= rel_t_in;
         tally_ff   <= tally_in;
      end
   end

   // Status for zoom handling and polling; down_nx is the level after a scan
   assign stat.down      = down_ff;
   assign stat.down_nx   = take_press | (down_ff & ~take_rel);
   assign stat.pend_scan = pend_scan;
   assign stat.pending   = pend_ff;
   assign stat.hold_hit  = down_ff & (since_press > {16'd0, cfg.hold});
   assign stat.dbl_hit   = (tally_ff >= DOUBLE_COUNT) & (since_press < {16'd0, cfg.dclick});

endmodule

// File: rtl/bde_poll_arbiter.sv
`timescale 1ns / 1ps
module bde_poll_arbiter import bde_pkg::*; (
   input  bde_cell_stat_type    stat [BTN_SLOTS],
   output bde_event_type        kind,
   output logic [BTN_IDX_W-1:0] button,
   output logic [BTN_SLOTS-1:0] clr_pend,
   output logic [BTN_SLOTS-1:0] clr_tally
);

   logic found;

   // Lowest button first; per button press, then hold, then double click
   always_comb begin
      found     = 1'b0;
      kind      = EV_NONE;
      button    = '0;
      clr_pend  = '0;
      clr_tally = '0;
      for (int i = 0; i < BTN_SLOTS; i++) begin
         if (!found) begin
            priority if (stat[i].pending) begin
               found       = 1'b1;
               kind        = EV_PRESS;
               button      = BTN_IDX_W'(i);
               clr_pend[i] = 1'b1;
            end else if (stat[i].hold_hit) begin
               found  = 1'b1;
               kind   = EV_HOLD;
               button = BTN_IDX_W'(i);
            end else if (stat[i].dbl_hit) begin
               found        = 1'b1;
               kind         = EV_DOUBLE;
               button       = BTN_IDX_W'(i);
               clr_tally[i] = 1'b1;
            end else begin
               found = 1'b0;
            end
         end
      end
   end

endmodule

// File: rtl/button_debounce_event_engine.sv
`timescale 1ns / 1ps
// Debounce and event engine for eight active-low buttons. Each request item is
// either a scan (tuser 0: raw pin levels and the current millisecond time) or a
// poll (tuser 1) and gives exactly one response item. The block takes one item
// per clock cycle as long as the response side keeps taking items: an item is
// held in the input register, is resolved by the combinational per-button
// compare logic and the poll arbiter, and lands in the response register. The
// user must write the configuration registers over the APB-style port only
// while no item is in flight; the block itself does not enforce this.
module button_debounce_event_engine import bde_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [39:0]       req_tdata,  // raw_levels[7:0], now_ms[39:8]
   input  logic              req_tuser,  // mode[0]
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_W-1:0]  rsp_tdata,  // event_kind[1:0], event_button[4:2],
                                         // down_mask[12:5], zoom_now[17:13],
                                         // center_select[18], scan_taken[19]
   // configuration port
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   bde_cfg_type cfg;

   // Input register
   logic                 in_vld_ff, in_vld_in;
   logic                 in_mode_ff;
   logic [BTN_SLOTS-1:0] in_raw_ff;
   logic [31:0]          in_now_ff;

   // Shared state
   logic [31:0] last_scan_ff, last_scan_in;
   logic [4:0]  zoom_ff, zoom_in;

   // Response register
   logic                 out_vld_ff, out_vld_in;
   bde_event_type        out_kind_ff;
   logic [BTN_IDX_W-1:0] out_btn_ff;
   logic [BTN_SLOTS-1:0] out_down_ff;
   logic [4:0]           out_zoom_ff;
   logic                 out_sel_ff;
   logic                 out_taken_ff;

   logic                 fire, accept, scan_go, poll_go, gate_ok;
   bde_cell_stat_type    stat [BTN_SLOTS];
   logic [BTN_SLOTS-1:0] pend_scan, pend_left, consume, down_nx;
   logic [4:0]           zoom_v;
   logic                 sel_v;
   bde_event_type        poll_kind;
   logic [BTN_IDX_W-1:0] poll_btn;
   logic [BTN_SLOTS-1:0] poll_clr_pend, poll_clr_tally;

   bde_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // Handshake: resolve the held item whenever the response slot frees up
   assign fire       = in_vld_ff & (~out_vld_ff | rsp_tready);
   assign req_tready = ~in_vld_ff | fire;
   assign accept     = req_tvalid & req_tready;
   assign in_vld_in  = accept | (in_vld_ff & ~fire);
   assign out_vld_in = fire | (out_vld_ff & ~rsp_tready);

   // Scan interval gate
   assign gate_ok = (in_now_ff - last_scan_ff) >= {24'd0, cfg.scan_iv};
   assign scan_go = fire & (in_mode_ff == MODE_SCAN) & gate_ok;
   assign poll_go = fire & (in_mode_ff == MODE_POLL);

   // Button cells; slots past the button count stay idle
   for (genvar i = 0; i < BTN_SLOTS; i++) begin : g_btn
      if (i < BUTTONS) begin : g_cell
         bde_cell_ctl_type ctl;
         assign ctl.scan      = scan_go;
         assign ctl.clr_pend  = (scan_go & consume[i]) | (poll_go & poll_clr_pend[i]);
         assign ctl.clr_tally = poll_go & poll_clr_tally[i];
         bde_button_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .ctl     (ctl),
            .pressed (~in_raw_ff[i]),
            .now_ms  (in_now_ff),
            .cfg     (cfg),
            .stat    (stat[i])
         );
      end else begin : g_none
         assign stat[i] = '0;
      end
      assign pend_scan[i] = stat[i].pend_scan;
      assign down_nx[i]   = scan_go ? stat[i].down_nx : stat[i].down;
   end

   // Zoom in, then zoom out, then centre select on presses still pending
   always_comb begin
      pend_left = pend_scan;
      zoom_v    = zoom_ff;
      sel_v     = 1'b0;
      if (pend_left[ZOOM_IN_BUTTON]) begin
         if (zoom_v < cfg.zoom_hi) begin
            zoom_v = zoom_v + 5'd1;
         end
         pend_left[ZOOM_IN_BUTTON] = 1'b0;
      end
      if (pend_left[ZOOM_OUT_BUTTON]) begin
         if (zoom_v > cfg.zoom_lo) begin
            zoom_v = zoom_v - 5'd1;
         end
         pend_left[ZOOM_OUT_BUTTON] = 1'b0;
      end
      if (pend_left[CENTER_BUTTON]) begin
         sel_v = 1'b1;
         pend_left[CENTER_BUTTON] = 1'b0;
      end
   end

   assign consume      = pend_scan & ~pend_left;
   assign zoom_in      = scan_go ? zoom_v : zoom_ff;
   assign last_scan_in = scan_go ? in_now_ff : last_scan_ff;

   bde_poll_arbiter u_arb (
      .stat      (stat),
      .kind      (poll_kind),
      .button    (poll_btn),
      .clr_pend  (poll_clr_pend),
      .clr_tally (poll_clr_tally)
   );

   // Control and shared state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         last_scan_ff <= 32'd0;
         zoom_ff      <= ZOOM_START;
      end else begin
         in_vld_ff    <= in_vld_in;
         out_vld_ff   <= out_vld_in;
         last_scan_ff <= last_scan_in;
         zoom_ff      <= zoom_in;
      end
   end

   // Capture the request item
   always_ff @(posedge clock) begin
      if (accept) begin
         in_mode_ff <= req_tuser;
         in_raw_ff  <= req_tdata[BTN_SLOTS-1:0];
         in_now_ff  <= req_tdata[39:8];
      end
   end

   // Load the response item
   always_ff @(posedge clock) begin
      if (fire) begin
         out_kind_ff  <= poll_go ? poll_kind : EV_NONE;
         out_btn_ff   <= poll_go ? poll_btn : '0;
         out_down_ff  <= down_nx;
         out_zoom_ff  <= zoom_in;
         out_sel_ff   <= scan_go & sel_v;
         out_taken_ff <= scan_go;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'd0, out_taken_ff, out_sel_ff, out_zoom_ff, out_down_ff,
                        out_btn_ff, out_kind_ff};

endmodule

// File: rtl/bde_checker.sv
`timescale 1ns / 1ps
`include "button_debounce_event_engine_defines.svh"
module bde_checker import bde_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic       rsp_fire;
   logic [1:0] kind;
   logic [2:0] button;
   logic       select;
   logic       taken;

   assign rsp_fire = rsp_tvalid & rsp_tready;
   assign kind     = rsp_tdata[RSP_KIND_LSB +: 2];
   assign button   = rsp_tdata[RSP_BTN_LSB +: 3];
   assign select   = rsp_tdata[RSP_SELECT_BIT];
   assign taken    = rsp_tdata[RSP_TAKEN_BIT];

   // An event item never carries scan results
   `BDE_ASSERT_IMP(a_event_not_scan, rsp_fire && (kind != EV_NONE), !taken && !select, "event item flagged as scan")
   // Select only comes from a scan that passed the gate
   `BDE_ASSERT_IMP(a_select_needs_scan, rsp_fire && select, taken, "select without taken scan")
   // No event means button index zero
   `BDE_ASSERT_IMP(a_none_button_zero, rsp_fire && (kind == EV_NONE), button == 3'd0, "button set without event")
   // A stalled response item stays offered
   `BDE_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped while stalled")

endmodule

bind button_debounce_event_engine bde_checker u_bde_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
